// ===== sv/ais_position_report_encoder_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the position report encoder
// ---------------------------------------------------------------------------
`ifndef AIS_POSITION_REPORT_ENCODER_CORE_ASSERT_SVH
`define AIS_POSITION_REPORT_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, idle while arst_n is low
`define AISENC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AISENC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/aisenc_pkg.sv =====
// ---------------------------------------------------------------------------
// aisenc_pkg
// Widths, constants and field helpers for the type 1 report encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aisenc_pkg;

	localparam int MSG_BITS    = 168;
	localparam int CHAR_BITS   = 6;
	localparam int NUM_CHARS   = MSG_BITS / CHAR_BITS;
	localparam int IDX_W       = $clog2(NUM_CHARS);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [9:0]  SOG_MAX    = 10'd1022;
	localparam logic [11:0] COG_MAX    = 12'd3599;
	localparam logic [9:0]  HDG_LIMIT  = 10'd359;
	localparam logic [8:0]  HDG_NA     = 9'd511;
	localparam logic [5:0]  TIME_STAMP = 6'd60;
	localparam logic [5:0]  MSG_TYPE   = 6'd1;
	localparam logic [6:0]  ARMOR_BASE = 7'h30;
	localparam logic [6:0]  ARMOR_GAP  = 7'h57;
	localparam logic [6:0]  ARMOR_SKIP = 7'h08;
	localparam logic [2:0]  FILL_NONE  = 3'd0;

	typedef logic [MSG_BITS-1:0] msg_t;

	typedef struct packed {
		logic valid;
		msg_t msg;
	} msg_beat_t;

	function automatic logic [9:0] sat_speed(input logic [11:0] raw);
		if (raw > {2'b00, SOG_MAX}) begin
			return SOG_MAX;
		end
		return raw[9:0];
	endfunction

	function automatic logic [11:0] sat_course(input logic [11:0] raw);
		if (raw > COG_MAX) begin
			return COG_MAX;
		end
		return raw;
	endfunction

	// sign bit set or past 359 degrees: heading not available
	function automatic logic [8:0] heading_code(input logic [9:0] raw);
		if (raw[9] || raw > HDG_LIMIT) begin
			return HDG_NA;
		end
		return raw[8:0];
	endfunction

	function automatic logic [6:0] armor(input logic [5:0] six);
		logic [6:0] c;
		c = {1'b0, six} + ARMOR_BASE;
		if (c > ARMOR_GAP) begin
			c = c + ARMOR_SKIP;
		end
		return c;
	endfunction

endpackage

// ===== sv/aisenc_in_if.sv =====
// ---------------------------------------------------------------------------
// aisenc_in_if
// Report channel: valid/ready plus the fields of one position report.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aisenc_in_if import aisenc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic        [29:0] ship_id;
	logic signed [27:0] lon_scaled;
	logic signed [26:0] lat_scaled;
	logic        [11:0] speed_tenths;
	logic        [11:0] course_tenths;
	logic signed [9:0]  heading_deg;

	modport source (
		output valid, ship_id, lon_scaled, lat_scaled, speed_tenths, course_tenths,
		       heading_deg,
		input  ready
	);
	modport sink (
		input  valid, ship_id, lon_scaled, lat_scaled, speed_tenths, course_tenths,
		       heading_deg,
		output ready
	);
endinterface

// ===== sv/aisenc_out_if.sv =====
// ---------------------------------------------------------------------------
// aisenc_out_if
// Character channel: valid/ready plus one armored character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aisenc_out_if import aisenc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;
	logic       last_char;
	logic [2:0] fill_bits;

	modport source (output valid, ascii_char, last_char, fill_bits, input ready);
	modport sink   (input  valid, ascii_char, last_char, fill_bits, output ready);
endinterface

// ===== sv/ais_position_report_encoder_core.sv =====
// ---------------------------------------------------------------------------
// ais_position_report_encoder_core
// Type 1 position report encoder with six-bit ASCII armoring.
// ---------------------------------------------------------------------------
// Usage:
//   report : one position report per item (identity, position, speed, course,
//            heading). Speed, course and heading are clamped on the way in.
//   chars  : 28 items per report, one armored character each; last_char marks
//            the 28th, fill_bits is always zero.
// The first character of a report passes through the queue, the shifter
//   and the output register before it is valid, when the back end is idle.
// Throughput: one character per cycle while chars.ready is high; the rate
//   is set by the single six-bit output shifter. The next report is loaded
//   while the last character of the previous one goes out.
// The queue holds QUEUE_DEPTH packed reports, so the report channel keeps
//   accepting while characters wait to be taken.
// Reset clears the queue, the shifter state and the output valid; no item
//   is in flight afterwards.
// Stall: while chars.ready is low the current character holds, the shifter
//   waits, and report.ready drops once the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ais_position_report_encoder_core_assert.svh"

module ais_position_report_encoder_core import aisenc_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	aisenc_in_if.sink     report,
	aisenc_out_if.source  chars
);

	msg_beat_t push;
	msg_beat_t head;
	logic      q_full;
	logic      pop;

	aisenc_front u_front (
		.report (report),
		.q_full (q_full),
		.push   (push)
	);

	aisenc_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	aisenc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.chars  (chars)
	);

	`AISENC_ASSERT_NOW(a_pop_nonempty, pop, head.valid, "pop from empty queue")
	`AISENC_ASSERT_NOW(a_push_not_full, push.valid, !q_full, "push into full queue")
	`AISENC_ASSERT_NEXT(a_push_lands, push.valid, head.valid, "pushed item lost")

endmodule

// ===== sv/aisenc_front.sv =====
// ---------------------------------------------------------------------------
// aisenc_front
// Takes a report, clamps speed, course and heading, packs the 168-bit message.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aisenc_front import aisenc_pkg::*; (
	aisenc_in_if.sink  report,
	input  logic       q_full,
	output msg_beat_t  push
);

	assign report.ready = !q_full;

	always_comb begin
		push.valid = report.valid && !q_full;
		// msb first; unused fields zero, timestamp fixed
		push.msg = {
			MSG_TYPE, 2'b00, report.ship_id, 4'b0000, 8'h00,
			sat_speed(report.speed_tenths), 1'b0,
			report.lon_scaled, report.lat_scaled,
			sat_course(report.course_tenths),
			heading_code(report.heading_deg),
			TIME_STAMP, 2'b00, 3'b000, 1'b0, 19'd0
		};
	end

endmodule

// ===== sv/aisenc_queue.sv =====
// ---------------------------------------------------------------------------
// aisenc_queue
// Short queue of packed messages between the front and back halves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aisenc_queue import aisenc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  msg_beat_t push,
	input  logic      pop,
	output logic      full,
	output msg_beat_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	msg_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.msg   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/aisenc_back.sv =====
// ---------------------------------------------------------------------------
// aisenc_back
// Shifts a packed message out six bits at a time into a registered output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aisenc_back import aisenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  msg_beat_t   head,
	output logic        pop,
	aisenc_out_if.source chars
);

	msg_t             shift_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [6:0]       char_q;
	logic             last_q;
	logic             advance;
	logic             final_char;

	assign advance    = !out_valid_q || chars.ready;
	assign final_char = (idx_q == IDX_W'(NUM_CHARS - 1));
	// refill while the final character goes out, so reports run without a gap
	assign pop        = head.valid && (!busy_q || (advance && final_char));

	assign chars.valid      = out_valid_q;
	assign chars.ascii_char = char_q;
	assign chars.last_char  = last_q;
	assign chars.fill_bits  = FILL_NONE;

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			char_q <= armor(shift_q[MSG_BITS-1 -: CHAR_BITS]);
			last_q <= final_char;
		end
		if (pop) begin
			shift_q <= head.msg;
		end else if (advance && busy_q) begin
			shift_q <= shift_q << CHAR_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && busy_q) begin
				if (final_char) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== dv/tb_ais_position_report_encoder_core.sv =====
// ---------------------------------------------------------------------------
// tb_ais_position_report_encoder_core
// Checks the type 1 report encoder end to end. A directed table covers the
// field extremes and the clamped speed, course and heading; random reports
// follow. Every accepted report is packed and armored here, and each
// character taken from the block is compared with the oldest one waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ais_position_report_encoder_core;
	import aisenc_pkg::*;

	localparam int RANDOM_REPORTS = 410;
	localparam int IDLE_LIMIT     = 2000;
	localparam int SHOW_MAX       = 10;

	typedef struct packed {
		logic [29:0] ship_id;
		logic [27:0] lon;
		logic [26:0] lat;
		logic [11:0] speed;
		logic [11:0] course;
		logic [9:0]  heading;
	} report_t;

	typedef struct packed {
		logic [6:0] ascii;
		logic       last;
		logic [2:0] fill;
	} char_item_t;

	logic clk;
	logic arst_n;
	logic calm;

	aisenc_in_if  report_ch ();
	aisenc_out_if char_ch ();

	ais_position_report_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.report (report_ch),
		.chars  (char_ch)
	);

	char_item_t pending_chars[$];
	report_t    table_reports[$];
	string      table_text[$];
	int         error_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short pauses, now and then a long one
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10) begin
			return 0;
		end else if (sel < 17) begin
			return $urandom_range(1, 3);
		end else if (sel < 19) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic msg_t pack_report(input report_t r);
		logic [9:0]  sog;
		logic [11:0] cog;
		logic [8:0]  hdg;
		sog = (r.speed > {2'b00, SOG_MAX}) ? SOG_MAX : r.speed[9:0];
		cog = (r.course > COG_MAX) ? COG_MAX : r.course;
		// negative or past 359: not available
		hdg = (r.heading[9] || r.heading > HDG_LIMIT) ? HDG_NA : r.heading[8:0];
		return {MSG_TYPE, 2'b00, r.ship_id, 4'b0000, 8'h00, sog, 1'b0, r.lon, r.lat,
			cog, hdg, TIME_STAMP, 2'b00, 3'b000, 1'b0, 19'd0};
	endfunction

	// text, when typed in the table, overrides the computed characters
	task automatic queue_chars(input report_t r, input string text);
		msg_t       m;
		logic [5:0] six;
		logic [6:0] c;
		byte        ch;
		char_item_t item;
		m = pack_report(r);
		for (int i = 0; i < NUM_CHARS; i++) begin
			six = m[MSG_BITS-1-CHAR_BITS*i -: CHAR_BITS];
			c = {1'b0, six} + ARMOR_BASE;
			if (c > ARMOR_GAP) begin
				c = c + ARMOR_SKIP;
			end
			if (text.len() == NUM_CHARS) begin
				ch = text[i];
				c  = ch[6:0];
			end
			item.ascii = c;
			item.last  = (i == NUM_CHARS - 1);
			item.fill  = FILL_NONE;
			pending_chars.push_back(item);
		end
	endtask

	task automatic add_row(input logic [29:0] ship, input logic [27:0] lon,
			input logic [26:0] lat, input logic [11:0] speed, input logic [11:0] course,
			input logic [9:0] heading, input string text);
		report_t r;
		r = '{ship_id: ship, lon: lon, lat: lat, speed: speed, course: course,
			heading: heading};
		table_reports.push_back(r);
		table_text.push_back(text);
	endtask

	function automatic report_t random_report();
		report_t r;
		int      v;
		r.ship_id = 30'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			r.lon = 28'($urandom);
			r.lat = 27'($urandom);
		end else begin
			v = int'($urandom_range(0, 216000000)) - 108000000;
			r.lon = v[27:0];
			v = int'($urandom_range(0, 108000000)) - 54000000;
			r.lat = v[26:0];
		end
		case ($urandom_range(0, 3))
			0: r.speed = 12'($urandom);
			1: r.speed = 12'($urandom_range(1019, 1026));
			default: r.speed = 12'($urandom_range(0, 1022));
		endcase
		case ($urandom_range(0, 3))
			0: r.course = 12'($urandom);
			1: r.course = 12'($urandom_range(3596, 3603));
			default: r.course = 12'($urandom_range(0, 3599));
		endcase
		case ($urandom_range(0, 7))
			0: r.heading = '1;
			1: r.heading = 10'($urandom);
			2: r.heading = 10'($urandom_range(356, 363));
			default: r.heading = 10'($urandom_range(0, 359));
		endcase
		return r;
	endfunction

	task automatic send_report(input report_t r, input string text);
		int gap;
		gap = pick_gap();
		if (calm) begin
			gap = 0;
		end
		if (gap > 0) begin
			report_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		report_ch.valid         <= 1'b1;
		report_ch.ship_id       <= r.ship_id;
		report_ch.lon_scaled    <= r.lon;
		report_ch.lat_scaled    <= r.lat;
		report_ch.speed_tenths  <= r.speed;
		report_ch.course_tenths <= r.course;
		report_ch.heading_deg   <= r.heading;
		do @(posedge clk); while (!report_ch.ready);
		queue_chars(r, text);
	endtask

	task automatic check_char(input char_item_t got);
		char_item_t want;
		if (pending_chars.size() == 0) begin
			error_count++;
			if (error_count <= SHOW_MAX) begin
				$display("unexpected char item: ascii %h last %b fill %0d",
					got.ascii, got.last, got.fill);
			end
			return;
		end
		want = pending_chars.pop_front();
		if (got.ascii !== want.ascii || got.last !== want.last || got.fill !== want.fill) begin
			error_count++;
			if (error_count <= SHOW_MAX) begin
				$display("char mismatch: ascii %h/%h last %b/%b fill %0d/%0d (expected/actual)",
					want.ascii, got.ascii, want.last, got.last, want.fill, got.fill);
			end
		end
	endtask

	// character sink with random back-pressure
	initial begin : char_sink
		int stall_left;
		stall_left = 0;
		char_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (char_ch.valid && char_ch.ready) begin
				check_char('{ascii: char_ch.ascii_char, last: char_ch.last_char,
					fill: char_ch.fill_bits});
			end
			if (calm) begin
				char_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				char_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				char_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((report_ch.valid && report_ch.ready) || (char_ch.valid && char_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("ais_position_report_encoder_core test failed");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		calm   <= 1'b0;
		report_ch.valid         <= 1'b0;
		report_ch.ship_id       <= '0;
		report_ch.lon_scaled    <= '0;
		report_ch.lat_scaled    <= '0;
		report_ch.speed_tenths  <= '0;
		report_ch.course_tenths <= '0;
		report_ch.heading_deg   <= '0;

		// all zero, heading unavailable, speed clamped: typed in by hand
		add_row(30'd0, 28'd0, 27'd0, 12'd0, 12'd0, 10'd0,
			"10000000000000000000001p0000");
		add_row(30'd0, 28'd0, 27'd0, 12'd0, 12'd0, -10'sd1,
			"100000000000000000000?wp0000");
		add_row(30'd0, 28'd0, 27'd0, 12'd4095, 12'd0, 10'd0,
			"10000000?v0000000000001p0000");
		add_row(30'h3FFFFFFF, 28'd108000000, 27'd54000000, 12'd1022, 12'd3599, 10'd359, "");
		add_row(30'h3FFFFFFF, -28'sd108000000, -27'sd54000000, 12'd1023, 12'd3600,
			10'd360, "");
		add_row(30'h2AAAAAAA, 28'h7FFFFFF, 27'h3FFFFFF, 12'd1021, 12'd4095, 10'd511, "");
		add_row(30'h15555555, 28'h8000000, 27'h4000000, 12'd4095, 12'd3598, 10'h200, "");
		add_row(30'd1, 28'hFFFFFFF, 27'h7FFFFFF, 12'd0, 12'd0, 10'd358, "");
		add_row(30'd123456789, 28'd1, 27'd1, 12'd1, 12'd1, 10'd1, "");
		add_row(30'd987654321, 28'd61000000, -27'sd23000000, 12'd200, 12'd2700, 10'd270, "");
		add_row(30'h3FFFFFFF, 28'hFFFFFFF, 27'h7FFFFFF, 12'hFFF, 12'hFFF, 10'h3FF, "");
		add_row(30'd0, 28'd0, 27'd0, 12'd2048, 12'd2048, 10'h1FF, "");
		add_row(30'd366000000, -28'sd1, -27'sd1, 12'd1022, 12'd3599, 10'd0, "");

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_reports[i]) begin
			send_report(table_reports[i], table_text[i]);
		end
		for (int n = 0; n < RANDOM_REPORTS; n++) begin
			// a stretch with no pauses on either side
			calm <= (n >= 150 && n < 210);
			send_report(random_report(), "");
		end
		report_ch.valid <= 1'b0;
		calm <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("ais_position_report_encoder_core test passed");
		end else begin
			$display("ais_position_report_encoder_core test failed");
		end
		$finish;
	end

endmodule
